// ===== src/mled_pkg.sv =====
// Shared types and codes for the masked local extremum detector.
`timescale 1ns / 1ps
package mled_pkg;

    // Item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_FIND_MINIMUM    = 3'd2;
    localparam logic [2:0] REG_STRICT_MODE     = 3'd3;
    localparam logic [2:0] REG_NEIGHBOR_ENABLE = 3'd4;

    localparam int CFG_DATA_W = 11;
    localparam int OUT_POS_W  = 10;

    typedef enum logic {
        ST_RUN,
        ST_FILL
    } front_state_t;

    // Control carried with each column pushed to the back end
    typedef struct packed {
        logic emit;
        logic has_top;
        logic has_bot;
        logic has_left;
        logic has_right;
        logic last;
    } col_ctl_t;

endpackage

// ===== src/mled_queue.sv =====
// Small FIFO between the front end and the window back end.
`timescale 1ns / 1ps
module mled_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wdata,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] rdata
);
    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = count_reg == (PTR_W+1)'(DEPTH);
    assign valid   = count_reg != '0;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/mled_front.sv =====
// Front end: accepts items, tracks frame position and schedules column pushes.
`timescale 1ns / 1ps
module mled_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic                            q_full,
    output logic                            push,
    output mled_pkg::col_ctl_t              ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]    addr,
    output logic [$clog2(MAX_HEIGHT+1)-1:0] row,
    output logic [$clog2(MAX_WIDTH+1)-1:0]  col
);
    import mled_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(MAX_WIDTH + 3);

    front_state_t    state_reg, state_next;
    logic [CW-1:0]   rx_col_reg, rx_col_next;
    logic [HW-1:0]   rx_row_reg, rx_row_next;
    logic            rx_done_reg, rx_done_next;
    logic [CW-1:0]   e_col_reg, e_col_next;
    logic [HW-1:0]   e_row_reg, e_row_next;
    logic [LW-1:0]   rx_lag_reg, rx_lag_next;
    logic [LW-1:0]   push_lag_reg, push_lag_next;
    logic [CW-1:0]   p_col_reg, p_col_next;

    logic [LW-1:0]   wp2, rx_lag_n, pl_n;
    logic            acc, have_new, rx_last, e_last, clamp;
    logic            emit_due, sat, emit_now, go_fill;

    assign wp2     = LW'(width) + LW'(2);
    assign rx_last = (rx_row_reg == height - HW'(1)) && (rx_col_reg == width - CW'(1));
    assign e_last  = (e_row_reg == height - HW'(1)) && (e_col_reg == width - CW'(1));
    // Window reaches past the last pixel: wait for the whole frame instead
    assign clamp   = (e_row_reg == height - HW'(1))
                  || ((height >= HW'(2)) && (e_row_reg == height - HW'(2))
                      && (e_col_reg == width - CW'(1)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (go_fill)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (emit_now)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
        if (restart)
        begin
            state_next = ST_RUN;
        end
    end

    // Outputs and counters
    always_comb
    begin
        in_stall  = (state_reg != ST_RUN) || q_full;
        acc       = in_valid && !in_stall;
        have_new  = 1'b0;
        emit_due  = 1'b0;
        push      = 1'b0;
        go_fill   = 1'b0;
        rx_lag_n  = rx_lag_reg;

        unique case (state_reg)
            ST_RUN:
            begin
                have_new = acc && (opcode == OP_PIXEL) && !rx_done_reg;
                rx_lag_n = rx_lag_reg + LW'(have_new);
                if (acc)
                begin
                    emit_due = clamp ? (rx_done_reg || (have_new && rx_last))
                                     : (rx_lag_n >= wp2);
                end
                push = have_new || emit_due;
            end
            ST_FILL:
            begin
                emit_due = 1'b1;
                push     = !q_full;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase

        pl_n     = push_lag_reg + LW'(push);
        sat      = pl_n >= wp2;
        emit_now = push && emit_due && sat;
        go_fill  = (state_reg == ST_RUN) && emit_due && !sat;

        ctl.emit      = emit_now;
        ctl.has_top   = e_row_reg != '0;
        ctl.has_bot   = e_row_reg != height - HW'(1);
        ctl.has_left  = e_col_reg != '0;
        ctl.has_right = e_col_reg != width - CW'(1);
        ctl.last      = e_last;
        addr          = AW'(p_col_reg);
        row           = e_row_reg;
        col           = e_col_reg;

        rx_col_next   = rx_col_reg;
        rx_row_next   = rx_row_reg;
        rx_done_next  = rx_done_reg;
        e_col_next    = e_col_reg;
        e_row_next    = e_row_reg;
        rx_lag_next   = rx_lag_n;
        push_lag_next = pl_n;
        p_col_next    = p_col_reg;

        if (have_new)
        begin
            if (rx_last)
            begin
                rx_done_next = 1'b1;
            end
            else if (rx_col_reg == width - CW'(1))
            begin
                rx_col_next = '0;
                rx_row_next = rx_row_reg + HW'(1);
            end
            else
            begin
                rx_col_next = rx_col_reg + CW'(1);
            end
        end

        if (push)
        begin
            p_col_next = (p_col_reg == width - CW'(1)) ? '0 : p_col_reg + CW'(1);
        end

        if (emit_now)
        begin
            if (e_last)
            begin
                rx_col_next   = '0;
                rx_row_next   = '0;
                rx_done_next  = 1'b0;
                e_col_next    = '0;
                e_row_next    = '0;
                rx_lag_next   = '0;
                push_lag_next = '0;
                p_col_next    = '0;
            end
            else
            begin
                rx_lag_next   = rx_lag_n - LW'(1);
                push_lag_next = pl_n - LW'(1);
                if (e_col_reg == width - CW'(1))
                begin
                    e_col_next = '0;
                    e_row_next = e_row_reg + HW'(1);
                end
                else
                begin
                    e_col_next = e_col_reg + CW'(1);
                end
            end
        end

        if (restart)
        begin
            rx_col_next   = '0;
            rx_row_next   = '0;
            rx_done_next  = 1'b0;
            e_col_next    = '0;
            e_row_next    = '0;
            rx_lag_next   = '0;
            push_lag_next = '0;
            p_col_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            rx_col_reg   <= '0;
            rx_row_reg   <= '0;
            rx_done_reg  <= 1'b0;
            e_col_reg    <= '0;
            e_row_reg    <= '0;
            rx_lag_reg   <= '0;
            push_lag_reg <= '0;
            p_col_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rx_col_reg   <= rx_col_next;
            rx_row_reg   <= rx_row_next;
            rx_done_reg  <= rx_done_next;
            e_col_reg    <= e_col_next;
            e_row_reg    <= e_row_next;
            rx_lag_reg   <= rx_lag_next;
            push_lag_reg <= push_lag_next;
            p_col_reg    <= p_col_next;
        end
    end

    // Pushes never run more than one window ahead of the pixel being judged
    a_push_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push_lag_reg < wp2)
        else $error("push lag beyond window reach");

    // Virtual columns never overtake real pixels
    a_rx_lag_le_push: assert property (@(posedge clk) disable iff (!rst_n)
        rx_lag_reg <= push_lag_reg)
        else $error("received lag exceeds pushed lag");

    // Padding columns only once the whole frame is in
    a_fill_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> rx_done_reg)
        else $error("fill started before frame complete");

endmodule

// ===== src/mled_back.sv =====
// Back end: two-row line store, 3x3 window and extremum compare.
`timescale 1ns / 1ps
module mled_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 find_minimum,
    input  logic                                 strict_mode,
    input  logic [7:0]                           neighbor_enable,
    input  logic                                 q_valid,
    output logic                                 pop,
    input  mled_pkg::col_ctl_t                   q_ctl,
    input  logic [VALUE_BITS:0]                  q_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]         q_addr,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      q_row,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       q_col,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 is_extremum,
    output logic [mled_pkg::OUT_POS_W-1:0]       pixel_row,
    output logic [mled_pkg::OUT_POS_W-1:0]       pixel_col,
    output logic                                 frame_last
);
    import mled_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = VALUE_BITS + 1;

    // Word at a column: {row above current, two rows above}
    logic [2*PW-1:0] lb_mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_reg;
    logic [2*PW-1:0] fwd_data_reg;
    logic            fwd_reg;

    logic            s1_valid_reg;
    col_ctl_t        s1_ctl_reg;
    logic [PW-1:0]   s1_pix_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [HW-1:0]   s1_row_reg;
    logic [CW-1:0]   s1_col_reg;

    logic [PW-1:0]   left_reg [3];
    logic [PW-1:0]   mid_reg  [3];
    logic [PW-1:0]   new_col  [3];

    logic            out_valid_reg;
    logic            is_ext_reg;
    logic [OUT_POS_W-1:0] row_out_reg, col_out_reg;
    logic            last_reg;

    logic            adv, wr_en;
    logic [2*PW-1:0] rd_word, wr_data;
    logic [PW-1:0]   nb [8];
    logic [7:0]      nb_in, disq;
    logic [PW-1:0]   center;
    logic            judge;

    assign adv     = !out_valid_reg || !out_stall;
    assign pop     = adv && q_valid;
    assign wr_en   = adv && s1_valid_reg;
    assign rd_word = fwd_reg ? fwd_data_reg : rd_reg;
    assign wr_data = {s1_pix_reg, rd_word[2*PW-1:PW]};

    always_comb
    begin
        new_col[0] = rd_word[PW-1:0];
        new_col[1] = rd_word[2*PW-1:PW];
        new_col[2] = s1_pix_reg;
        center     = mid_reg[1];
        nb[0] = left_reg[0];
        nb[1] = mid_reg[0];
        nb[2] = new_col[0];
        nb[3] = left_reg[1];
        nb[4] = new_col[1];
        nb[5] = left_reg[2];
        nb[6] = mid_reg[2];
        nb[7] = new_col[2];
        nb_in[0] = s1_ctl_reg.has_top && s1_ctl_reg.has_left;
        nb_in[1] = s1_ctl_reg.has_top;
        nb_in[2] = s1_ctl_reg.has_top && s1_ctl_reg.has_right;
        nb_in[3] = s1_ctl_reg.has_left;
        nb_in[4] = s1_ctl_reg.has_right;
        nb_in[5] = s1_ctl_reg.has_bot && s1_ctl_reg.has_left;
        nb_in[6] = s1_ctl_reg.has_bot;
        nb_in[7] = s1_ctl_reg.has_bot && s1_ctl_reg.has_right;
        for (int j = 0; j < 8; j++)
        begin
            if (find_minimum)
            begin
                disq[j] = strict_mode ? (nb[j][PW-1:1] <= center[PW-1:1])
                                      : (nb[j][PW-1:1] <  center[PW-1:1]);
            end
            else
            begin
                disq[j] = strict_mode ? (nb[j][PW-1:1] >= center[PW-1:1])
                                      : (nb[j][PW-1:1] >  center[PW-1:1]);
            end
            disq[j] = disq[j] && neighbor_enable[j] && nb_in[j] && nb[j][0];
        end
        judge = center[0] && (disq == '0);
    end

    // Line store: read on pop, write back the shifted column on advance
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_reg       <= lb_mem[q_addr];
            fwd_data_reg <= wr_data;
        end
        if (wr_en)
        begin
            lb_mem[s1_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fwd_reg       <= pop && wr_en && (q_addr == s1_addr_reg);
            s1_valid_reg  <= q_valid;
            out_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_ctl_reg  <= q_ctl;
            s1_pix_reg  <= q_pix;
            s1_addr_reg <= q_addr;
            s1_row_reg  <= q_row;
            s1_col_reg  <= q_col;
        end
        if (wr_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                left_reg[k] <= mid_reg[k];
                mid_reg[k]  <= new_col[k];
            end
            if (s1_ctl_reg.emit)
            begin
                is_ext_reg  <= judge;
                row_out_reg <= OUT_POS_W'(s1_row_reg);
                col_out_reg <= OUT_POS_W'(s1_col_reg);
                last_reg    <= s1_ctl_reg.last;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_extremum = is_ext_reg;
    assign pixel_row   = row_out_reg;
    assign pixel_col   = col_out_reg;
    assign frame_last  = last_reg;

endmodule

// ===== src/masked_local_extremum_detector.sv =====
// Top level of the masked 3x3 local extremum detector.
// The item completing a window passes the queue, s1 and output registers before out_valid rises.
// Throughput: one item per cycle, unless the output stalls or the front end pads a frame end.
// One-row frames stall the input at their end to pad the window, and so does a 1x2 frame.
// Reset clears counters, queue and pipeline; registers return to 640x480, maxima, all neighbors.
// The line store is not cleared: rows above the frame are masked by the position flags.
`timescale 1ns / 1ps
module masked_local_extremum_detector #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              write_enable,
    input  logic [2:0]                        write_index,
    input  logic [mled_pkg::CFG_DATA_W-1:0]   write_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [15:0]                       pixel_value,
    input  logic                              in_region,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              is_extremum,
    output logic [mled_pkg::OUT_POS_W-1:0]    pixel_row,
    output logic [mled_pkg::OUT_POS_W-1:0]    pixel_col,
    output logic                              frame_last
);
    import mled_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = VALUE_BITS + 1;
    localparam int CTL_W = $bits(col_ctl_t);
    localparam int Q_W = CTL_W + PW + AW + HW + CW;

    // Configuration registers
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;
    logic                  find_minimum_reg;
    logic                  strict_mode_reg;
    logic [7:0]            neighbor_enable_reg;

    logic [CW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    // Front to queue
    logic          f_push;
    col_ctl_t      f_ctl;
    logic [AW-1:0] f_addr;
    logic [HW-1:0] f_row;
    logic [CW-1:0] f_col;
    logic [PW-1:0] f_pix;
    logic          q_full;

    // Queue to back
    logic          q_valid, q_pop;
    logic [Q_W-1:0] q_wdata, q_rdata;
    col_ctl_t      q_ctl;
    logic [PW-1:0] q_pix;
    logic [AW-1:0] q_addr;
    logic [HW-1:0] q_row;
    logic [CW-1:0] q_col;

    // Any write restarts the frame; unknown indexes only restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg     <= CFG_DATA_W'(640);
            image_height_reg    <= CFG_DATA_W'(480);
            find_minimum_reg    <= 1'b0;
            strict_mode_reg     <= 1'b0;
            neighbor_enable_reg <= 8'hFF;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                REG_IMAGE_WIDTH:     image_width_reg     <= write_data;
                REG_IMAGE_HEIGHT:    image_height_reg    <= write_data;
                REG_FIND_MINIMUM:    find_minimum_reg    <= write_data[0];
                REG_STRICT_MODE:     strict_mode_reg     <= write_data[0];
                REG_NEIGHBOR_ENABLE: neighbor_enable_reg <= write_data[7:0];
                default:             ;
            endcase
        end
    end

    // Saturate frame size to 1..MAX
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_eff = CW'(1);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            width_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = CW'(image_width_reg);
        end

        if (image_height_reg == '0)
        begin
            height_eff = HW'(1);
        end
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
        begin
            height_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = HW'(image_height_reg);
        end
    end

    // Stored pixel: value above the region flag
    assign f_pix = {VALUE_BITS'(pixel_value), in_region};

    mled_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (write_enable),
        .width    (width_eff),
        .height   (height_eff),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .q_full   (q_full),
        .push     (f_push),
        .ctl      (f_ctl),
        .addr     (f_addr),
        .row      (f_row),
        .col      (f_col)
    );

    assign q_wdata = {f_ctl, f_pix, f_addr, f_row, f_col};
    assign {q_ctl, q_pix, q_addr, q_row, q_col} = q_rdata;

    mled_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    mled_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .find_minimum    (find_minimum_reg),
        .strict_mode     (strict_mode_reg),
        .neighbor_enable (neighbor_enable_reg),
        .q_valid         (q_valid),
        .pop             (q_pop),
        .q_ctl           (q_ctl),
        .q_pix           (q_pix),
        .q_addr          (q_addr),
        .q_row           (q_row),
        .q_col           (q_col),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .is_extremum     (is_extremum),
        .pixel_row       (pixel_row),
        .pixel_col       (pixel_col),
        .frame_last      (frame_last)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the masked 3x3 local extremum detector.
`timescale 1ns / 1ps
module testbench;
    import mled_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int RING_DEPTH    = 2 * MAX_W + 2;
    localparam int DRAIN_CYCLES  = 12;      // pipeline latency plus frame-end padding, with margin
    localparam int WATCHDOG_MAX  = 20000;   // cycles with no item moving on either side
    localparam int RANDOM_ITEMS  = 540;     // pixels; flush items come on top of these
    localparam int HOLD_CYCLES   = 400;
    localparam logic [2:0] REG_SPARE = 3'd5; // past the register list; still restarts the frame

    // One result item of the block
    typedef struct packed {
        logic                 ext;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
        logic                 last;
    } extremum_t;

    // One row of the directed table; known marks a result whose verdict is typed in
    typedef struct packed {
        logic        op;
        logic [15:0] value;
        logic        region;
        logic        known;
        logic        ext;
    } dir_row_t;

    // Frame of 3x2 pixels: a bright corner peak, a gap in the region, drain by flush items,
    // and a trailing flush with nothing left to emit.
    localparam dir_row_t DIRECTED [12] = '{
        '{OP_PIXEL, 16'hFFFF, 1'b1, 1'b0, 1'b0},
        '{OP_FLUSH, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{OP_PIXEL, 16'h0000, 1'b1, 1'b0, 1'b0},
        '{OP_PIXEL, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{OP_PIXEL, 16'h0000, 1'b1, 1'b0, 1'b0},
        '{OP_PIXEL, 16'h0001, 1'b1, 1'b1, 1'b1},   // completes the corner peak's window
        '{OP_PIXEL, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{OP_FLUSH, 16'h0000, 1'b0, 1'b1, 1'b0},   // pixel outside the region
        '{OP_FLUSH, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{OP_FLUSH, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{OP_FLUSH, 16'h0000, 1'b0, 1'b1, 1'b0},   // last pixel, outside the region
        '{OP_FLUSH, 16'h0000, 1'b0, 1'b0, 1'b0}    // nothing ready
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  write_enable = 1'b0;
    logic [2:0]            write_index = '0;
    logic [CFG_DATA_W-1:0] write_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  opcode = OP_PIXEL;
    logic [15:0]           pixel_value = '0;
    logic                  in_region = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  is_extremum;
    logic [OUT_POS_W-1:0]  pixel_row;
    logic [OUT_POS_W-1:0]  pixel_col;
    logic                  frame_last;

    masked_local_extremum_detector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .pixel_value  (pixel_value),
        .in_region    (in_region),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_extremum  (is_extremum),
        .pixel_row    (pixel_row),
        .pixel_col    (pixel_col),
        .frame_last   (frame_last)
    );

    always #5 clk = ~clk;

    // Predictor state: mirror of the configuration, pixel ring and frame counters
    logic [16:0] pixel_ring [RING_DEPTH];   // {value, region}
    int          rx_count;
    int          tx_count;
    int          cfg_width  = 640;
    int          cfg_height = 480;
    logic        cfg_minimum = 1'b0;
    logic        cfg_strict  = 1'b0;
    logic [7:0]  cfg_enable  = 8'hFF;
    bit          frame_wrapped;

    extremum_t   pending_results [$];
    int          fail_count;
    int          idle_cycles;
    int          burst_left;
    bit          no_gaps;

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Word at a frame index; the item being accepted now is not in the ring yet
    function automatic logic [16:0] ring_word(int idx, bit fresh, int fresh_idx,
                                              logic [16:0] fresh_word);
        if (fresh && idx == fresh_idx) return fresh_word;
        return pixel_ring[idx % RING_DEPTH];
    endfunction

    function automatic logic window_verdict(int e, int w, int h, bit fresh, int fresh_idx,
                                            logic [16:0] fresh_word);
        logic [16:0] self_word;
        logic [16:0] nb_word;
        int r;
        int c;
        int nr;
        int nc;
        self_word = ring_word(e, fresh, fresh_idx, fresh_word);
        r = e / w;
        c = e % w;
        if (!self_word[0]) return 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            // raster order around the center, center skipped
            nr = r + ((j < 3) ? -1 : (j < 5) ? 0 : 1);
            nc = c + ((j == 0 || j == 3 || j == 5) ? -1 :
                      (j == 1 || j == 6) ? 0 : 1);
            if (!cfg_enable[j]) continue;
            if (nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
            nb_word = ring_word(nr * w + nc, fresh, fresh_idx, fresh_word);
            if (!nb_word[0]) continue;
            if (cfg_minimum)
            begin
                if (cfg_strict ? (nb_word[16:1] <= self_word[16:1])
                               : (nb_word[16:1] <  self_word[16:1])) return 1'b0;
            end
            else
            begin
                if (cfg_strict ? (nb_word[16:1] >= self_word[16:1])
                               : (nb_word[16:1] >  self_word[16:1])) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advance the frame by one accepted item; tell whether it releases a result
    function automatic void advance_frame(logic op, logic [15:0] value, logic region,
                                          output bit emitted, output extremum_t res);
        int w;
        int h;
        int n;
        int need;
        int e;
        bit fresh;
        int fresh_idx;
        logic [16:0] fresh_word;
        w = clamp_dim(cfg_width, MAX_W);
        h = clamp_dim(cfg_height, MAX_H);
        n = w * h;
        e = tx_count;
        fresh = 1'b0;
        fresh_idx = 0;
        fresh_word = '0;
        emitted = 1'b0;
        res = '0;
        if (op == OP_PIXEL && rx_count < n)
        begin
            fresh = 1'b1;
            fresh_idx = rx_count;
            fresh_word = {value, region};
            rx_count++;
        end
        need = (e + w + 2 > n) ? n : e + w + 2;
        if (e < n && rx_count >= need)
        begin
            res.ext  = window_verdict(e, w, h, fresh, fresh_idx, fresh_word);
            res.row  = OUT_POS_W'(e / w);
            res.col  = OUT_POS_W'(e % w);
            res.last = (e + 1 == n);
            emitted = 1'b1;
            tx_count = e + 1;
        end
        if (fresh) pixel_ring[fresh_idx % RING_DEPTH] = fresh_word;
        if (emitted && tx_count >= n)
        begin
            rx_count = 0;
            tx_count = 0;
            frame_wrapped = 1'b1;
        end
    endfunction

    // Offer one item, hold it until accepted, then predict; called at a rising edge
    task automatic send_item(logic op, logic [15:0] value, logic region,
                             bit known = 1'b0, logic known_ext = 1'b0);
        bit        emitted;
        extremum_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps && $urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        opcode      <= op;
        pixel_value <= value;
        in_region   <= region;
        do @(posedge clk); while (in_stall);
        advance_frame(op, value, region, emitted, res);
        if (emitted)
        begin
            if (known) res.ext = known_ext;
            pending_results.push_back(res);
        end
    endtask

    // Drop valid and wait until every expected result is out and the pipe is quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:     cfg_width   = int'(data);
            REG_IMAGE_HEIGHT:    cfg_height  = int'(data);
            REG_FIND_MINIMUM:    cfg_minimum = data[0];
            REG_STRICT_MODE:     cfg_strict  = data[0];
            REG_NEIGHBOR_ENABLE: cfg_enable  = data[7:0];
            default: ;
        endcase
        rx_count = 0;
        tx_count = 0;
    endtask

    task automatic set_config(int w, int h, logic mn, logic st, logic [7:0] en);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_FIND_MINIMUM, CFG_DATA_W'(mn));
        write_reg(REG_STRICT_MODE, CFG_DATA_W'(st));
        write_reg(REG_NEIGHBOR_ENABLE, CFG_DATA_W'(en));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE | 3'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
        write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // One frame of random content; may be abandoned part way to test the restart
    task automatic run_frame(int w, int h);
        int   n;
        int   stop_at;
        int   style;
        logic [15:0] v;
        logic rg;
        n = clamp_dim(w, MAX_W) * clamp_dim(h, MAX_H);
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n + 1;
        style = $urandom_range(0, 3);
        frame_wrapped = 1'b0;
        for (int k = 0; k < n && !frame_wrapped; k++)
        begin
            if (k == stop_at) return;
            if ($urandom_range(0, 9) == 0) send_item(OP_FLUSH, 16'($urandom), 1'($urandom));
            if (frame_wrapped) break;
            case (style)
                0:       v = 16'($urandom_range(0, 3));        // plenty of ties
                1:       v = 16'($urandom);
                2:       v = 16'h7FFE + 16'($urandom_range(0, 3));
                default: v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom_range(0, 7));
            endcase
            rg = ($urandom_range(0, 3) != 0);
            send_item(OP_PIXEL, v, rg);
        end
        // drain; an extra pixel on a full frame is dropped and acts as a flush
        while (!frame_wrapped)
        begin
            if ($urandom_range(0, 4) == 0) send_item(OP_PIXEL, 16'($urandom), 1'($urandom));
            else send_item(OP_FLUSH, 16'($urandom), 1'($urandom));
        end
    endtask

    // Compare each result against the oldest expectation
    always @(posedge clk)
    begin
        extremum_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result row %0d col %0d", pixel_row, pixel_col);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (is_extremum !== want.ext)
                begin
                    $error("is_extremum expected %0d got %0d", want.ext, is_extremum);
                    fail_count++;
                end
                if (pixel_row !== want.row)
                begin
                    $error("pixel_row expected %0d got %0d", want.row, pixel_row);
                    fail_count++;
                end
                if (pixel_col !== want.col)
                begin
                    $error("pixel_col expected %0d got %0d", want.col, pixel_col);
                    fail_count++;
                end
                if (frame_last !== want.last)
                begin
                    $error("frame_last expected %0d got %0d", want.last, frame_last);
                    fail_count++;
                end
            end
        end
    end

    // Output back-pressure: the pattern steps through four modes in turn; two long hold-offs start
    // while a result waits and the sender is offering, so the block fills up
    int rx_cycle;
    int hold_left;
    int holds_done;
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (holds_done < 2 && rx_cycle >= 400 + 600 * holds_done
                 && in_valid && out_valid)
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            case ((rx_cycle >> 9) % 4)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 1) != 0);
                2:       out_stall <= (rx_cycle % 8 == 0);
                default: out_stall <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("masked_local_extremum_detector verification failed");
            $finish;
        end
    end

    initial
    begin
        int sent_pixels;
        int w;
        int h;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frame of 3x2, maxima, all neighbors
        set_config(3, 2, 1'b0, 1'b0, 8'hFF);
        no_gaps = 1'b1;
        frame_wrapped = 1'b0;
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].region,
                      DIRECTED[i].known, DIRECTED[i].ext);
        settle();

        // zero sizes, saturated up to one
        set_config(0, 0, 1'b1, 1'b0, 8'h00);
        run_frame(0, 0);
        settle();
        set_config(0, 5, 1'b1, 1'b1, 8'h42);
        run_frame(0, 5);
        settle();
        set_config(7, 0, 1'b0, 1'b0, 8'h18);
        run_frame(7, 0);
        settle();

        // random small frames
        sent_pixels = 0;
        while (sent_pixels < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            h = $urandom_range(1, 6);
            no_gaps = ($urandom_range(0, 3) == 0);
            set_config(w, h, 1'($urandom), 1'($urandom),
                       ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom));
            run_frame(w, h);
            sent_pixels += w * h;
            if ($urandom_range(0, 4) == 0)
            begin
                // pause the sender until every expected result has come
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            settle();
        end

        settle();
        if (fail_count == 0)
            $display("masked_local_extremum_detector verification clean");
        else
            $display("masked_local_extremum_detector verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mled_pkg.sv
src/mled_queue.sv
src/mled_front.sv
src/mled_back.sv
src/masked_local_extremum_detector.sv
tb/sv/testbench.sv
